@@ sv/tpgr_pkg.sv @@
// shared codes and pad helper functions for the touch pad gesture recognizer
`default_nettype none

package tpgr_pkg;

  localparam int unsigned LevelBitsDefault = 16;

  localparam int unsigned StateBits = 5;
  localparam int unsigned PadBits   = 3;
  localparam int unsigned CodeBits  = 3;

  // tracking states
  localparam logic [StateBits-1:0] StIdle      = 5'd0;
  localparam logic [StateBits-1:0] StLastStart = 5'd4;
  localparam logic [StateBits-1:0] StLastSwipe = 5'd8;
  localparam logic [StateBits-1:0] StCwBegin   = 5'd9;
  localparam logic [StateBits-1:0] StCcwBegin  = 5'd13;
  localparam logic [StateBits-1:0] StLastValid = 5'd16;

  // pad codes
  localparam logic [PadBits-1:0] PadNone   = 3'd0;
  localparam logic [PadBits-1:0] PadLeft   = 3'd1;
  localparam logic [PadBits-1:0] PadUp     = 3'd2;
  localparam logic [PadBits-1:0] PadRight  = 3'd3;
  localparam logic [PadBits-1:0] PadDown   = 3'd4;
  localparam logic [PadBits-1:0] PadCentre = 3'd5;

  // gesture codes
  localparam logic [CodeBits-1:0] GestNone     = 3'd0;
  localparam logic [CodeBits-1:0] GestReleased = 3'd1;
  localparam logic [CodeBits-1:0] GestRight    = 3'd2;
  localparam logic [CodeBits-1:0] GestLeft     = 3'd3;
  localparam logic [CodeBits-1:0] GestUp       = 3'd4;
  localparam logic [CodeBits-1:0] GestDown     = 3'd5;
  localparam logic [CodeBits-1:0] GestCw       = 3'd6;
  localparam logic [CodeBits-1:0] GestCcw      = 3'd7;

  // neighbor one step clockwise round the outer pads
  function automatic logic [PadBits-1:0] pad_cw(input logic [PadBits-1:0] p);
    return {1'b0, p[1:0]} + 3'd1;
  endfunction

  // neighbor one step counterclockwise
  function automatic logic [PadBits-1:0] pad_ccw(input logic [PadBits-1:0] p);
    return {1'b0, p[1:0] + 2'd2} + 3'd1;
  endfunction

  // pad across the centre
  function automatic logic [PadBits-1:0] pad_opp(input logic [PadBits-1:0] p);
    return {1'b0, p[1:0] + 2'd1} + 3'd1;
  endfunction

endpackage

`default_nettype wire

@@ sv/touch_pad_gesture_recognizer_unit.sv @@
// top level of the touch pad gesture recognizer
`default_nettype none

// One scan of the five-pad cross enters per request and yields one gesture code.
// The strongest touched pad is picked by a compare chain in the order left, up,
// right, down, centre, with ties going to the later pad. The tracking state machine
// and the output code register both load when the scan is accepted, so the code shows in the next cycle.
// A new scan is accepted every cycle while the output is empty or being taken, so
// the sustained rate is one scan per clock; the loops are the tracking state,
// previous pad and circling registers.
module touch_pad_gesture_recognizer_unit #(
  parameter int unsigned LevelBits = tpgr_pkg::LevelBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 left_touched_i,
  input  wire logic                 up_touched_i,
  input  wire logic                 right_touched_i,
  input  wire logic                 down_touched_i,
  input  wire logic                 centre_touched_i,
  input  wire logic [LevelBits-1:0] left_level_i,
  input  wire logic [LevelBits-1:0] up_level_i,
  input  wire logic [LevelBits-1:0] right_level_i,
  input  wire logic [LevelBits-1:0] down_level_i,
  input  wire logic [LevelBits-1:0] centre_level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                gesture_code_o
);

  localparam int unsigned SB = tpgr_pkg::StateBits;
  localparam int unsigned PB = tpgr_pkg::PadBits;
  localparam int unsigned CB = tpgr_pkg::CodeBits;

  logic [SB-1:0] track_state_q, track_state_d;
  logic [PB-1:0] previous_pad_q, previous_pad_d;
  logic          circling_q, circling_d;
  logic          out_valid_q;
  logic [CB-1:0] code_q, code_d;

  logic          in_fire;
  logic [7:0]    tf;
  logic [7:0]    fv;
  logic          any_touch;
  logic [LevelBits-1:0] lv [1:5];
  logic [PB-1:0]        w_idx;
  logic [LevelBits-1:0] w_lv;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign tf = {2'b00, centre_touched_i, down_touched_i, right_touched_i,
               up_touched_i, left_touched_i, 1'b0};
  assign any_touch = |tf[5:1];

  assign lv[1] = left_touched_i  ? left_level_i  : '0;
  assign lv[2] = up_touched_i    ? up_level_i    : '0;
  assign lv[3] = right_touched_i ? right_level_i : '0;
  assign lv[4] = down_touched_i  ? down_level_i  : '0;
  assign lv[5] = (centre_touched_i && !circling_q) ? centre_level_i : '0;

  // strongest pad, ties go to the later pad
  always_comb begin
    w_idx = tpgr_pkg::PadLeft;
    w_lv  = lv[1];
    for (int i = 2; i <= 5; i++) begin
      if (!(w_lv > lv[i])) begin
        w_idx = PB'(i);
        w_lv  = lv[i];
      end
    end
  end

  always_comb begin
    fv        = '0;
    fv[w_idx] = tf[w_idx];
  end

  always_comb begin
    logic [SB-1:0] st;
    logic [PB-1:0] p;
    logic [PB-1:0] s;
    logic [PB-1:0] t;
    logic [PB-1:0] adv;
    logic [PB-1:0] back;
    logic [1:0]    phase;
    logic          ccw;
    logic          hit;
    logic          circ_clr;

    circ_clr   = !any_touch && circling_q;
    st         = circ_clr ? tpgr_pkg::StIdle : track_state_q;
    p          = previous_pad_q;
    circling_d = circ_clr ? 1'b0 : circling_q;
    code_d     = any_touch ? tpgr_pkg::GestNone : tpgr_pkg::GestReleased;
    s          = st[PB-1:0];
    t          = PB'(st - 5'd4);
    phase      = 2'(st - tpgr_pkg::StCwBegin);
    ccw        = st >= tpgr_pkg::StCcwBegin;
    adv        = ccw ? tpgr_pkg::pad_ccw(p) : tpgr_pkg::pad_cw(p);
    back       = ccw ? tpgr_pkg::pad_cw(p) : tpgr_pkg::pad_ccw(p);
    hit        = 1'b0;

    priority if (st == tpgr_pkg::StIdle) begin
      for (int i = 1; i <= 4; i++) begin
        if (fv[i]) begin
          st = SB'(i);
        end
      end
      p = tpgr_pkg::PadNone;
    end else if (st <= tpgr_pkg::StLastStart) begin
      if (fv[tpgr_pkg::PadCentre] && !fv[tpgr_pkg::pad_cw(s)] &&
          !fv[tpgr_pkg::pad_ccw(s)] && !circling_q) begin
        st = 5'd4 + {2'b00, tpgr_pkg::pad_opp(s)};
      end
      if (fv[tpgr_pkg::pad_cw(s)]) begin
        st = tpgr_pkg::StCwBegin;
        p  = s;
      end
      if (fv[tpgr_pkg::pad_ccw(s)]) begin
        st = tpgr_pkg::StCcwBegin;
        p  = s;
      end
    end else if (st <= tpgr_pkg::StLastSwipe) begin
      if (t == tpgr_pkg::PadLeft) begin
        hit = !fv[tpgr_pkg::PadRight] && fv[tpgr_pkg::PadLeft];
      end else if (t == tpgr_pkg::PadDown) begin
        hit = !fv[tpgr_pkg::PadUp] && fv[tpgr_pkg::PadDown];
      end else begin
        hit = fv[t];
      end
      if (hit) begin
        unique case (t)
          tpgr_pkg::PadRight: code_d = tpgr_pkg::GestRight;
          tpgr_pkg::PadLeft:  code_d = tpgr_pkg::GestLeft;
          tpgr_pkg::PadUp:    code_d = tpgr_pkg::GestUp;
          default:            code_d = tpgr_pkg::GestDown;
        endcase
        st = tpgr_pkg::StIdle;
      end
    end else if (st <= tpgr_pkg::StLastValid) begin
      if (p < tpgr_pkg::PadLeft || p > tpgr_pkg::PadDown) begin
        st = tpgr_pkg::StIdle;
      end else if (!fv[p] && fv[adv]) begin
        if (phase != 2'd3) begin
          st = st + 5'd1;
          p  = adv;
        end else begin
          code_d     = ccw ? tpgr_pkg::GestCcw : tpgr_pkg::GestCw;
          circling_d = 1'b1;
          st         = tpgr_pkg::StIdle;
        end
      end else if (!fv[p] && fv[back]) begin
        if (phase == 2'd2) begin
          st = ccw ? tpgr_pkg::StCwBegin : tpgr_pkg::StCcwBegin;
        end else begin
          st = tpgr_pkg::StIdle;
        end
        p = tpgr_pkg::PadNone;
      end
    end else begin
      st     = tpgr_pkg::StIdle;
      code_d = tpgr_pkg::GestNone;
    end

    if (code_d == tpgr_pkg::GestReleased) begin
      st = tpgr_pkg::StIdle;
    end

    track_state_d  = st;
    previous_pad_d = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_state_q  <= tpgr_pkg::StIdle;
      previous_pad_q <= tpgr_pkg::PadNone;
      circling_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        track_state_q  <= track_state_d;
        previous_pad_q <= previous_pad_d;
        circling_q     <= circling_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gesture_code_o = code_q;

`ifndef SYNTHESIS
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    track_state_q <= tpgr_pkg::StLastValid)
    else $error("tracking state out of range");

  a_pad_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    previous_pad_q <= tpgr_pkg::PadDown)
    else $error("previous pad out of range");

  a_release_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !any_touch |=> track_state_q == tpgr_pkg::StIdle && !circling_q &&
      gesture_code_o == tpgr_pkg::GestReleased)
    else $error("release did not return to idle");

  a_circling_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(circling_q) |-> out_valid_o &&
      (gesture_code_o == tpgr_pkg::GestCw || gesture_code_o == tpgr_pkg::GestCcw))
    else $error("circling set without a rotation");
`endif

endmodule

`default_nettype wire
